FILE: design/d2pc_pkg.sv
// Shared types, constants and helpers of the depth-to-point converter.
`timescale 1ns / 1ps
`default_nettype none

package d2pc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIM_REG_W  = 13;
    localparam int LIMIT_W    = 16;
    localparam int FOCAL_W    = 32;
    localparam int COLOR_W    = 24;
    localparam int COORD_W    = 32;
    localparam int Z_W        = 16;
    localparam int CLASS_W    = 2;
    localparam int MUL_W      = 32;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_ENABLE = 3'd5;

    typedef enum logic [CLASS_W-1:0] {
        CLS_VALID = 2'd0,
        CLS_NEAR  = 2'd1,
        CLS_FAR   = 2'd2
    } range_class_t;

    // operand selection of the shared multiplier
    typedef enum logic [2:0] {
        MUL_IDLE = 3'd0,
        MUL_DX   = 3'd1,
        MUL_DY   = 3'd2,
        MUL_LX   = 3'd3,
        MUL_HX   = 3'd4,
        MUL_LY   = 3'd5,
        MUL_HY   = 3'd6
    } mul_op_t;

    typedef struct packed {
        logic [DIM_REG_W-1:0] frame_width;
        logic [DIM_REG_W-1:0] frame_height;
        logic [LIMIT_W-1:0]   near_limit;
        logic [LIMIT_W-1:0]   far_limit;
        logic [FOCAL_W-1:0]   inv_focal;
        logic                 color_enable;
    } cfg_t;

    typedef struct packed {
        logic    accept;
        mul_op_t mul_op;
        logic    saturate;
        logic    emit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // Scales the split product back by 2^25 with round half up on the magnitude,
    // then clamps to the signed 32-bit range of the given sign.
    function automatic logic [COORD_W-1:0] sat_mag(
        input logic [2*MUL_W-1:0] hi,
        input logic [2*MUL_W-1:0] lo,
        input logic               neg
    );
        logic [39:0] val;
        logic [39:0] limit;
        limit = neg ? 40'h0080000000 : 40'h007FFFFFFF;
        val   = {9'd0, hi[23:0], 7'd0} + {1'b0, lo[63:25]} + {39'd0, lo[24]};
        if (|hi[63:24])
        begin
            val = limit;
        end
        else if (val > limit)
        begin
            val = limit;
        end
        return val[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/d2pc_interfaces.sv
// Stream interfaces for depth pixels in and points out.
`timescale 1ns / 1ps
`default_nettype none

interface d2pc_pixel_if #(parameter int DEPTH_BITS = 16);
    import d2pc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DEPTH_BITS-1:0] depth_mm;
    logic [COLOR_W-1:0]    pixel_color;

    modport source (output valid, depth_mm, pixel_color, input ready);
    modport sink   (input valid, depth_mm, pixel_color, output ready);
endinterface

interface d2pc_point_if;
    import d2pc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [Z_W-1:0]            point_z;
    logic [CLASS_W-1:0]        range_class;
    logic [COLOR_W-1:0]        point_color;
    logic                      frame_last;
    logic                      frame_dense;

    modport source (output valid, point_x, point_y, point_z, range_class, point_color,
                    frame_last, frame_dense, input ready);
    modport sink   (input valid, point_x, point_y, point_z, range_class, point_color,
                    frame_last, frame_dense, output ready);
endinterface

`default_nettype wire

FILE: design/d2pc_cfg.sv
// Configuration register file of the depth-to-point converter.
`timescale 1ns / 1ps
`default_nettype none

module d2pc_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [d2pc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [d2pc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output d2pc_pkg::cfg_t                        cfg
);
    import d2pc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_data[DIM_REG_W-1:0];
                REG_FRAME_HEIGHT: cfg_next.frame_height = cfg_data[DIM_REG_W-1:0];
                REG_NEAR_LIMIT:   cfg_next.near_limit   = cfg_data[LIMIT_W-1:0];
                REG_FAR_LIMIT:    cfg_next.far_limit    = cfg_data[LIMIT_W-1:0];
                REG_INV_FOCAL:    cfg_next.inv_focal    = cfg_data[FOCAL_W-1:0];
                REG_COLOR_ENABLE: cfg_next.color_enable = cfg_data[0];
                default:          cfg_next = cfg_reg;   // unused index, dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= 13'd640;
            cfg_reg.frame_height <= 13'd480;
            cfg_reg.near_limit   <= 16'd400;
            cfg_reg.far_limit    <= 16'd65535;
            cfg_reg.inv_focal    <= 32'd26214;
            cfg_reg.color_enable <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: design/d2pc_ctrl.sv
// Sequencer: steps one pixel through the shared multiplier and out.
`timescale 1ns / 1ps
`default_nettype none

module d2pc_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire d2pc_pkg::dp_status_t  status,
    output d2pc_pkg::dp_cmd_t          cmd
);
    import d2pc_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_DX   = 9'b000000010,
        ST_DY   = 9'b000000100,
        ST_LX   = 9'b000001000,
        ST_HX   = 9'b000010000,
        ST_LY   = 9'b000100000,
        ST_HY   = 9'b001000000,
        ST_SAT  = 9'b010000000,
        ST_EMIT = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.mul_op   = MUL_IDLE;
        cmd.saturate = 1'b0;
        cmd.emit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DX;
                end
            end
            ST_DX:
            begin
                cmd.mul_op = MUL_DX;
                state_next = ST_DY;
            end
            ST_DY:
            begin
                cmd.mul_op = MUL_DY;
                state_next = ST_LX;
            end
            ST_LX:
            begin
                cmd.mul_op = MUL_LX;
                state_next = ST_HX;
            end
            ST_HX:
            begin
                cmd.mul_op = MUL_HX;
                state_next = ST_LY;
            end
            ST_LY:
            begin
                cmd.mul_op = MUL_LY;
                state_next = ST_HY;
            end
            ST_HY:
            begin
                cmd.mul_op = MUL_HY;
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                cmd.saturate = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == ST_DX)
        else $error("accepted beat did not start the multiply sequence");

    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && !status.out_free |=> state_reg == ST_EMIT)
        else $error("result left emit state while output slot was full");

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("pixel side ready while a beat is in flight");

endmodule

`default_nettype wire

FILE: design/d2pc_dp.sv
// Datapath: pixel counters, range classing, shared multiplier, saturation, output slot.
`timescale 1ns / 1ps
`default_nettype none

module d2pc_dp #(
    parameter int DEPTH_BITS = 16,
    parameter int MAX_DIM    = 4096
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire d2pc_pkg::cfg_t                      cfg,
    input  wire d2pc_pkg::dp_cmd_t                   cmd,
    output d2pc_pkg::dp_status_t                     status,
    input  wire logic [DEPTH_BITS-1:0]               depth_mm,
    input  wire logic [d2pc_pkg::COLOR_W-1:0]        pixel_color,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic signed [d2pc_pkg::COORD_W-1:0]      point_x,
    output logic signed [d2pc_pkg::COORD_W-1:0]      point_y,
    output logic [d2pc_pkg::Z_W-1:0]                 point_z,
    output logic [d2pc_pkg::CLASS_W-1:0]             range_class,
    output logic [d2pc_pkg::COLOR_W-1:0]             point_color,
    output logic                                     frame_last,
    output logic                                     frame_dense
);
    import d2pc_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int DIM_W = CNT_W + 1;
    localparam int A2_W  = DIM_W + 1;
    localparam int M_W   = DEPTH_BITS + DIM_W;

    // frame geometry, clamped to 1..MAX_DIM
    logic [DIM_W-1:0] w_dim;
    logic [DIM_W-1:0] h_dim;

    always_comb
    begin
        if (cfg.frame_width == '0)
            w_dim = DIM_W'(1);
        else if (32'(cfg.frame_width) > 32'(MAX_DIM))
            w_dim = DIM_W'(MAX_DIM);
        else
            w_dim = DIM_W'(cfg.frame_width);

        if (cfg.frame_height == '0)
            h_dim = DIM_W'(1);
        else if (32'(cfg.frame_height) > 32'(MAX_DIM))
            h_dim = DIM_W'(MAX_DIM);
        else
            h_dim = DIM_W'(cfg.frame_height);
    end

    // counters and frame flag
    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic             all_valid_reg, all_valid_next;

    logic             row_end, last;
    range_class_t     cls;
    logic             pix_valid;
    logic signed [A2_W-1:0] a2x, a2y;
    logic [DIM_W-1:0] magx, magy;

    always_comb
    begin
        row_end = ({1'b0, col_reg} + DIM_W'(1)) >= w_dim;
        last    = row_end && (({1'b0, row_reg} + DIM_W'(1)) >= h_dim);

        if (32'(depth_mm) <= 32'(cfg.near_limit))
            cls = CLS_NEAR;
        else if (32'(depth_mm) >= 32'(cfg.far_limit))
            cls = CLS_FAR;
        else
            cls = CLS_VALID;
        pix_valid = (cls == CLS_VALID);

        // offset from the centre in half pixels
        a2x  = $signed({1'b0, col_reg, 1'b0}) - $signed({1'b0, w_dim - DIM_W'(1)});
        a2y  = $signed({1'b0, row_reg, 1'b0}) - $signed({1'b0, h_dim - DIM_W'(1)});
        magx = a2x[A2_W-1] ? DIM_W'(-a2x) : DIM_W'(a2x);
        magy = a2y[A2_W-1] ? DIM_W'(-a2y) : DIM_W'(a2y);

        col_next       = col_reg;
        row_next       = row_reg;
        all_valid_next = all_valid_reg;
        if (cmd.accept)
        begin
            if (last)
            begin
                col_next       = '0;
                row_next       = '0;
                all_valid_next = 1'b1;
            end
            else
            begin
                if (row_end)
                begin
                    col_next = '0;
                    row_next = row_reg + CNT_W'(1);
                end
                else
                begin
                    col_next = col_reg + CNT_W'(1);
                end
                if (!pix_valid)
                    all_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            all_valid_reg <= 1'b1;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            all_valid_reg <= all_valid_next;
        end
    end

    // captured pixel
    logic [DEPTH_BITS-1:0] depth_reg;
    logic [COLOR_W-1:0]    color_reg;
    range_class_t          class_reg;
    logic                  last_reg;
    logic                  dense_reg;
    logic                  negx_reg, negy_reg;
    logic [DIM_W-1:0]      magx_reg, magy_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            depth_reg <= depth_mm;
            color_reg <= cfg.color_enable ? pixel_color : '0;
            class_reg <= cls;
            last_reg  <= last;
            dense_reg <= last && all_valid_reg && pix_valid;
            negx_reg  <= a2x[A2_W-1];
            negy_reg  <= a2y[A2_W-1];
            magx_reg  <= magx;
            magy_reg  <= magy;
        end
    end

    // shared 32x32 multiplier
    logic [M_W-1:0]       mx_reg, my_reg;
    logic [2*MUL_W-1:0]   mx_ext, my_ext;
    logic [2*MUL_W-1:0]   lo_x_reg, hi_x_reg, lo_y_reg, hi_y_reg;
    logic [MUL_W-1:0]     mul_a, mul_b;
    logic [2*MUL_W-1:0]   mul_p;

    assign mx_ext = (2*MUL_W)'(mx_reg);
    assign my_ext = (2*MUL_W)'(my_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            MUL_DX:
            begin
                mul_a = MUL_W'(depth_reg);
                mul_b = MUL_W'(magx_reg);
            end
            MUL_DY:
            begin
                mul_a = MUL_W'(depth_reg);
                mul_b = MUL_W'(magy_reg);
            end
            MUL_LX:
            begin
                mul_a = mx_ext[MUL_W-1:0];
                mul_b = cfg.inv_focal;
            end
            MUL_HX:
            begin
                mul_a = mx_ext[2*MUL_W-1:MUL_W];
                mul_b = cfg.inv_focal;
            end
            MUL_LY:
            begin
                mul_a = my_ext[MUL_W-1:0];
                mul_b = cfg.inv_focal;
            end
            MUL_HY:
            begin
                mul_a = my_ext[2*MUL_W-1:MUL_W];
                mul_b = cfg.inv_focal;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);
    end

    always_ff @(posedge clk)
    begin
        case (cmd.mul_op)
            MUL_DX:  mx_reg   <= M_W'(mul_p);
            MUL_DY:  my_reg   <= M_W'(mul_p);
            MUL_LX:  lo_x_reg <= mul_p;
            MUL_HX:  hi_x_reg <= mul_p;
            MUL_LY:  lo_y_reg <= mul_p;
            MUL_HY:  hi_y_reg <= mul_p;
            default: ;
        endcase
    end

    // rounding and clamping of both magnitudes
    logic [COORD_W-1:0] sat_x_reg, sat_y_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.saturate)
        begin
            sat_x_reg <= sat_mag(hi_x_reg, lo_x_reg, negx_reg);
            sat_y_reg <= sat_mag(hi_y_reg, lo_y_reg, negy_reg);
        end
    end

    // output slot
    logic                      out_valid_reg, out_valid_next;
    logic signed [COORD_W-1:0] x_reg, y_reg;
    logic [Z_W-1:0]            z_reg;
    range_class_t              out_class_reg;
    logic [COLOR_W-1:0]        out_color_reg;
    logic                      out_last_reg, out_dense_reg;
    logic [31:0]               depth_ext;

    assign depth_ext       = 32'(depth_reg);
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (class_reg == CLS_VALID)
            begin
                x_reg <= negx_reg ? $signed(32'd0 - sat_x_reg) : $signed(sat_x_reg);
                y_reg <= negy_reg ? $signed(32'd0 - sat_y_reg) : $signed(sat_y_reg);
                z_reg <= depth_ext[Z_W-1:0];
            end
            else
            begin
                x_reg <= '0;
                y_reg <= '0;
                z_reg <= '0;
            end
            out_class_reg <= class_reg;
            out_color_reg <= color_reg;
            out_last_reg  <= last_reg;
            out_dense_reg <= dense_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign point_x     = x_reg;
    assign point_y     = y_reg;
    assign point_z     = z_reg;
    assign range_class = out_class_reg;
    assign point_color = out_color_reg;
    assign frame_last  = out_last_reg;
    assign frame_dense = out_dense_reg;

    a_dense_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_dense_reg |-> out_last_reg)
        else $error("frame_dense set on a beat that is not the frame end");

    a_invalid_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_class_reg != CLS_VALID |-> x_reg == '0 && y_reg == '0 && z_reg == '0)
        else $error("out-of-range point carries coordinates");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && last |=> col_reg == '0 && row_reg == '0 && all_valid_reg)
        else $error("counters not restarted after the last pixel");

endmodule

`default_nettype wire

FILE: design/depth_to_point_cloud_top.sv
// Top level of the depth-to-point converter: config, sequencer and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Turns a raster stream of depth pixels into 3-D points with a pinhole camera
// model. Each pixel beat on 'pixels' yields exactly one point beat on 'points',
// in order. Column and row are counted internally; x and y are
// depth * (2*col - (w-1)) * inv_focal / 2^25, rounded half away from zero and
// saturated to 32 bits signed. Depths at or below near_limit are classed near,
// at or above far_limit far (near wins), and such points carry zero x, y, z.
// frame_last marks the last pixel of a frame and frame_dense then says whether
// the whole frame was in range. Timing: a pixel is captured at its accepting
// edge, then takes six passes through the single shared 32x32 multiplier
// (depth times offset for x and y, then low and high halves against inv_focal
// for each), a rounding and saturation step and an emit step into the output
// register; a full output register holds the emit until the sink takes the
// waiting point. The next pixel is accepted in the cycle after the emit, so a
// new pixel is taken only once the last one has been emitted; the output
// register lets a point wait for the sink while the next pixel is already
// being worked on. Configuration is written through
// cfg_write/cfg_index/cfg_data and should only change while no pixel is in
// flight. No clearing pass after reset.
module depth_to_point_cloud_top #(
    parameter int DEPTH_BITS = 16,
    parameter int MAX_DIM    = 4096
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [d2pc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [d2pc_pkg::CFG_DATA_W-1:0]  cfg_data,
    d2pc_pixel_if.sink                            pixels,
    d2pc_point_if.source                          points
);
    import d2pc_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    // register file; the user must write it only between beats, the block does not enforce this
    d2pc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: accept, six multiplies, saturate, emit
    d2pc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixels.valid),
        .in_ready (pixels.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // counters, classing, multiplier, output slot
    d2pc_dp #(
        .DEPTH_BITS (DEPTH_BITS),
        .MAX_DIM    (MAX_DIM)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .status      (status),
        .depth_mm    (pixels.depth_mm),
        .pixel_color (pixels.pixel_color),
        .out_ready   (points.ready),
        .out_valid   (points.valid),
        .point_x     (points.point_x),
        .point_y     (points.point_y),
        .point_z     (points.point_z),
        .range_class (points.range_class),
        .point_color (points.point_color),
        .frame_last  (points.frame_last),
        .frame_dense (points.frame_dense)
    );

endmodule

`default_nettype wire
